// ----- rtl/tfd_pkg.sv -----
`default_nettype none

package tfd_pkg;

   localparam int FINGERS_DEFAULT = 2;

   localparam int WORD_W      = 32;
   localparam int POS_W       = 12;
   localparam int AGE_W       = 8;
   localparam int KIND_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int RESULTS     = 5;
   localparam int RES_IDX_W   = $clog2(RESULTS);

   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_ZONE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_X        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_Y        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_HEIGHT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLING_WINDOW   = 3'd5;

   localparam logic [WORD_W-1:0] DEAD_ZONE_RESET      = 32'd49152;
   localparam logic [WORD_W-1:0] SCALE_X_RESET        = 32'd9830;
   localparam logic [WORD_W-1:0] SCALE_Y_RESET        = 32'd17640;
   localparam logic [WORD_W-1:0] INVERSE_WIDTH_RESET  = 32'd2236962;
   localparam logic [WORD_W-1:0] INVERSE_HEIGHT_RESET = 32'd4013974;
   localparam logic [AGE_W-1:0]  FLING_WINDOW_RESET   = 8'd50;

   localparam logic [KIND_W-1:0] KIND_TOUCH = 3'd0;
   localparam logic [KIND_W-1:0] KIND_X_NEG = 3'd1;
   localparam logic [KIND_W-1:0] KIND_X_POS = 3'd2;
   localparam logic [KIND_W-1:0] KIND_Y_NEG = 3'd3;
   localparam logic [KIND_W-1:0] KIND_Y_POS = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ABS_X = 3'd5;
   localparam logic [KIND_W-1:0] KIND_ABS_Y = 3'd6;

   localparam logic [AGE_W-1:0]  AGE_MAX    = 8'hFF;
   localparam logic [WORD_W-1:0] TOUCH_ONE  = 32'h0001_0000;
   localparam logic [WORD_W-1:0] ROUND_HALF = 32'h0000_8000;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic                     touching;
      logic [POS_W-1:0]         last_x;
      logic [POS_W-1:0]         last_y;
      logic signed [WORD_W-1:0] held_x;
      logic [AGE_W-1:0]         age_x;
      logic signed [WORD_W-1:0] held_y;
      logic [AGE_W-1:0]         age_y;
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/tfd_req_if.sv -----
`default_nettype none

interface tfd_req_if;
   import tfd_pkg::*;

   logic              valid;
   logic              ready;
   logic              finger;
   logic [WORD_W-1:0] packed_touch;

   modport source (output valid, output finger, output packed_touch, input ready);
   modport sink   (input valid, input finger, input packed_touch, output ready);
endinterface

`default_nettype wire

// ----- rtl/tfd_rsp_if.sv -----
`default_nettype none

interface tfd_rsp_if;
   import tfd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        event_kind;
   logic                     finger_slot;
   logic signed [WORD_W-1:0] event_value;
   logic                     last;

   modport source (output valid, output event_kind, output finger_slot,
                   output event_value, output last, input ready);
   modport sink   (input valid, input event_kind, input finger_slot,
                   input event_value, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/touchpad_finger_delta_tracker_unit.sv -----
`default_nettype none

// channel   dir  handshake         payload
// req_chan  in   valid/ready       finger, packed_touch
// rsp_chan  out  valid/ready       event_kind, finger_slot, event_value, last
// csr_*     in   csr_write         csr_index, csr_data
//
// an item enters every cycle while the stages ahead can take it; it passes a read
// stage, a multiply stage and an emit stage on its way to the result port
// each item puts zero to five results on the single result port, one per result
// finger state lives in a small memory that is read into a register on accept, with
// forwarding from the write-back stage; reset marks every entry as zero at once
// a stalled rsp_chan backs up through the stages to req_chan.ready

module touchpad_finger_delta_tracker_unit #(
   parameter int FINGERS = tfd_pkg::FINGERS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tfd_req_if.sink                             req_chan,
   tfd_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_write,
   input  wire logic [tfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tfd_pkg::WORD_W-1:0]      csr_data
);
   import tfd_pkg::*;

   localparam int FIDX_W = (FINGERS > 1) ? $clog2(FINGERS) : 1;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [45:0] p);
      if ((&p[45:31]) || (~|p[45:31])) begin
         sat_word = p[WORD_W-1:0];
      end else if (p[45]) begin
         sat_word = WORD_MIN;
      end else begin
         sat_word = WORD_MAX;
      end
   endfunction

   function automatic logic signed [WORD_W-1:0] neg_sat(input logic signed [WORD_W-1:0] d);
      if (d == WORD_MIN) begin
         neg_sat = WORD_MAX;
      end else begin
         neg_sat = -d;
      end
   endfunction

   // configuration
   logic [WORD_W-1:0] dead_zone_ff;
   logic [WORD_W-1:0] scale_x_ff;
   logic [WORD_W-1:0] scale_y_ff;
   logic [WORD_W-1:0] inverse_width_ff;
   logic [WORD_W-1:0] inverse_height_ff;
   logic [AGE_W-1:0]  fling_window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff      <= DEAD_ZONE_RESET;
         scale_x_ff        <= SCALE_X_RESET;
         scale_y_ff        <= SCALE_Y_RESET;
         inverse_width_ff  <= INVERSE_WIDTH_RESET;
         inverse_height_ff <= INVERSE_HEIGHT_RESET;
         fling_window_ff   <= FLING_WINDOW_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEAD_ZONE:      dead_zone_ff      <= csr_data;
            CSR_SCALE_X:        scale_x_ff        <= csr_data;
            CSR_SCALE_Y:        scale_y_ff        <= csr_data;
            CSR_INVERSE_WIDTH:  inverse_width_ff  <= csr_data;
            CSR_INVERSE_HEIGHT: inverse_height_ff <= csr_data;
            CSR_FLING_WINDOW:   fling_window_ff   <= csr_data[AGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline control
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s1_adv;
   logic s2_adv;
   logic s3_free;
   logic req_fire;
   logic in_range;
   logic s1_load;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign in_range = (FINGERS > 1) || (req_chan.finger == 1'b0);
   assign s1_load  = req_fire && in_range;
   assign req_chan.ready = !s1_valid_ff || s1_adv;

   // finger state memory
   state_type          state_mem [FINGERS];
   logic [FINGERS-1:0] mem_valid_ff;
   state_type          rd_ff;
   logic               wr_en;
   logic [FIDX_W-1:0]  wr_addr;
   state_type          wr_data;
   logic [FIDX_W-1:0]  req_addr;
   logic [FIDX_W-1:0]  s1_addr;

   logic               s1_finger_ff;
   logic [WORD_W-1:0]  s1_word_ff;

   assign req_addr = FIDX_W'(req_chan.finger);
   assign s1_addr  = FIDX_W'(s1_finger_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= '0;
      end else if (wr_en) begin
         mem_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         if (wr_en && (wr_addr == req_addr)) begin
            rd_ff <= wr_data;
         end else if (mem_valid_ff[req_addr]) begin
            rd_ff <= state_mem[req_addr];
         end else begin
            rd_ff <= '0;
         end
      end else if (wr_en && s1_valid_ff && (wr_addr == s1_addr)) begin
         rd_ff <= wr_data;
      end
   end

   // stage 1: forward, difference, multiply
   logic                     s2_finger_ff;
   logic                     s2_touch_ff;
   logic                     s2_changed_ff;
   logic [POS_W-1:0]         s2_px_ff;
   logic [POS_W-1:0]         s2_py_ff;
   logic signed [45:0]       s2_prod_x_ff;
   logic signed [45:0]       s2_prod_y_ff;
   logic [43:0]              s2_abs_x_ff;
   logic [43:0]              s2_abs_y_ff;
   logic signed [WORD_W-1:0] s2_held_x_ff;
   logic signed [WORD_W-1:0] s2_held_y_ff;
   logic [AGE_W-1:0]         s2_age_x_ff;
   logic [AGE_W-1:0]         s2_age_y_ff;

   logic               s1_fwd;
   logic               prev_touch;
   logic [POS_W-1:0]   prev_x;
   logic [POS_W-1:0]   prev_y;
   logic               touch1;
   logic [POS_W-1:0]   px1;
   logic [POS_W-1:0]   py1;
   logic               changed1;
   logic signed [12:0] ddx;
   logic signed [12:0] ddy;
   logic signed [45:0] prod_x;
   logic signed [45:0] prod_y;
   logic [43:0]        abs_prod_x;
   logic [43:0]        abs_prod_y;
   logic               xfer_hit;
   state_type          xfer_state;

   assign s1_fwd     = s2_valid_ff && (s2_finger_ff == s1_finger_ff);
   assign prev_touch = s1_fwd ? s2_touch_ff : rd_ff.touching;
   assign prev_x     = s1_fwd ? s2_px_ff : rd_ff.last_x;
   assign prev_y     = s1_fwd ? s2_py_ff : rd_ff.last_y;

   assign touch1   = ~s1_word_ff[7];
   assign px1      = s1_word_ff[19:8];
   assign py1      = s1_word_ff[31:20];
   assign changed1 = touch1 != prev_touch;

   assign ddx        = $signed({1'b0, px1}) - $signed({1'b0, prev_x});
   assign ddy        = $signed({1'b0, py1}) - $signed({1'b0, prev_y});
   assign prod_x     = ddx * $signed({1'b0, scale_x_ff});
   assign prod_y     = ddy * $signed({1'b0, scale_y_ff});
   assign abs_prod_x = 44'(px1) * 44'(inverse_width_ff);
   assign abs_prod_y = 44'(py1) * 44'(inverse_height_ff);

   assign xfer_hit   = wr_en && (wr_addr == s1_addr);
   assign xfer_state = xfer_hit ? wr_data : rd_ff;

   assign s1_adv = s1_valid_ff && (!s2_valid_ff || s2_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= in_range;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_finger_ff <= req_chan.finger;
         s1_word_ff   <= req_chan.packed_touch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_adv) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_finger_ff  <= s1_finger_ff;
         s2_touch_ff   <= touch1;
         s2_changed_ff <= changed1;
         s2_px_ff      <= px1;
         s2_py_ff      <= py1;
         s2_prod_x_ff  <= prod_x;
         s2_prod_y_ff  <= prod_y;
         s2_abs_x_ff   <= abs_prod_x;
         s2_abs_y_ff   <= abs_prod_y;
         s2_held_x_ff  <= xfer_state.held_x;
         s2_held_y_ff  <= xfer_state.held_y;
         s2_age_x_ff   <= xfer_state.age_x;
         s2_age_y_ff   <= xfer_state.age_y;
      end
   end

   // stage 2: saturate, dead zone, results and write-back
   logic signed [WORD_W-1:0] dx;
   logic signed [WORD_W-1:0] dy;
   logic signed [33:0]       dz_pos;
   logic signed [33:0]       dz_neg;
   logic signed [33:0]       dx_wide;
   logic signed [33:0]       dy_wide;
   logic                     x_neg;
   logic                     x_pos;
   logic                     y_neg;
   logic                     y_pos;
   logic                     x_emit;
   logic                     y_emit;
   logic [AGE_W-1:0]         age_x_eff;
   logic [AGE_W-1:0]         age_y_eff;
   logic                     absx_emit;
   logic                     absy_emit;
   logic [43:0]              absx_round;
   logic [43:0]              absy_round;
   logic [RESULTS-1:0]       mask2;
   logic [RESULTS-1:0][WORD_W-1:0] vals2;
   logic [RESULTS-1:0][KIND_W-1:0] kinds2;

   always_comb begin
      if (s2_changed_ff) begin
         dx = (!s2_touch_ff && (s2_age_x_ff < fling_window_ff)) ? s2_held_x_ff : '0;
         dy = (!s2_touch_ff && (s2_age_y_ff < fling_window_ff)) ? s2_held_y_ff : '0;
      end else begin
         dx = sat_word(s2_prod_x_ff);
         dy = sat_word(s2_prod_y_ff);
      end
   end

   assign dz_pos  = $signed({2'b00, dead_zone_ff});
   assign dz_neg  = -dz_pos;
   assign dx_wide = $signed({{2{dx[WORD_W-1]}}, dx});
   assign dy_wide = $signed({{2{dy[WORD_W-1]}}, dy});
   assign x_neg   = dx_wide < dz_neg;
   assign x_pos   = dx_wide > dz_pos;
   assign y_neg   = dy_wide < dz_neg;
   assign y_pos   = dy_wide > dz_pos;
   assign x_emit  = x_neg || x_pos;
   assign y_emit  = y_neg || y_pos;

   assign age_x_eff = x_emit ? '0 : s2_age_x_ff;
   assign age_y_eff = y_emit ? '0 : s2_age_y_ff;
   assign absx_emit = (age_x_eff == '0) || s2_changed_ff;
   assign absy_emit = (age_y_eff == '0) || s2_changed_ff;

   assign absx_round = s2_abs_x_ff + 44'(ROUND_HALF);
   assign absy_round = s2_abs_y_ff + 44'(ROUND_HALF);

   assign mask2 = {absy_emit, absx_emit, y_emit, x_emit, s2_changed_ff};

   assign vals2[0] = s2_touch_ff ? TOUCH_ONE : '0;
   assign vals2[1] = x_neg ? neg_sat(dx) : dx;
   assign vals2[2] = y_neg ? neg_sat(dy) : dy;
   assign vals2[3] = {4'b0000, absx_round[43:16]};
   assign vals2[4] = -$signed({4'b0000, absy_round[43:16]});

   assign kinds2[0] = KIND_TOUCH;
   assign kinds2[1] = x_neg ? KIND_X_NEG : KIND_X_POS;
   assign kinds2[2] = y_neg ? KIND_Y_NEG : KIND_Y_POS;
   assign kinds2[3] = KIND_ABS_X;
   assign kinds2[4] = KIND_ABS_Y;

   assign wr_en   = s2_adv;
   assign wr_addr = FIDX_W'(s2_finger_ff);

   always_comb begin
      wr_data.touching = s2_touch_ff;
      wr_data.last_x   = s2_px_ff;
      wr_data.last_y   = s2_py_ff;
      wr_data.held_x   = x_emit ? dx : s2_held_x_ff;
      wr_data.held_y   = y_emit ? dy : s2_held_y_ff;
      wr_data.age_x    = (age_x_eff == AGE_MAX) ? AGE_MAX : age_x_eff + 1'b1;
      wr_data.age_y    = (age_y_eff == AGE_MAX) ? AGE_MAX : age_y_eff + 1'b1;
   end

   assign s2_adv = s2_valid_ff && ((mask2 == '0) || s3_free);

   // stage 3: one result per cycle into the output register while rsp_chan is not stalled
   logic [RESULTS-1:0]             s3_mask_ff;
   logic [RESULTS-1:0]             s3_mask_in;
   logic [RESULTS-1:0][WORD_W-1:0] s3_vals_ff;
   logic [RESULTS-1:0][KIND_W-1:0] s3_kinds_ff;
   logic                           s3_finger_ff;
   logic [RES_IDX_W-1:0]           sel_idx;
   logic [RESULTS-1:0]             mask_rest;
   logic                           out_load;

   logic                     rsp_valid_ff;
   logic [KIND_W-1:0]        rsp_kind_ff;
   logic                     rsp_slot_ff;
   logic signed [WORD_W-1:0] rsp_value_ff;
   logic                     rsp_last_ff;

   always_comb begin
      sel_idx = '0;
      for (int i = RESULTS - 1; i >= 0; i--) begin
         if (s3_mask_ff[i]) begin
            sel_idx = RES_IDX_W'(i);
         end
      end
   end

   assign mask_rest = s3_mask_ff & ~(RESULTS'(1) << sel_idx);
   assign out_load  = (s3_mask_ff != '0) && (!rsp_valid_ff || rsp_chan.ready);
   assign s3_free   = (s3_mask_ff == '0) || (out_load && (mask_rest == '0));

   always_comb begin
      s3_mask_in = s3_mask_ff;
      if (s2_adv && (mask2 != '0)) begin
         s3_mask_in = mask2;
      end else if (out_load) begin
         s3_mask_in = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_mask_ff <= '0;
      end else begin
         s3_mask_ff <= s3_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && (mask2 != '0)) begin
         s3_vals_ff   <= vals2;
         s3_kinds_ff  <= kinds2;
         s3_finger_ff <= s2_finger_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff  <= s3_kinds_ff[sel_idx];
         rsp_value_ff <= s3_vals_ff[sel_idx];
         rsp_slot_ff  <= s3_finger_ff;
         rsp_last_ff  <= mask_rest == '0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.event_kind  = rsp_kind_ff;
   assign rsp_chan.finger_slot = rsp_slot_ff;
   assign rsp_chan.event_value = rsp_value_ff;
   assign rsp_chan.last        = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/tfd_checker.sv -----
`default_nettype none

module tfd_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [tfd_pkg::KIND_W-1:0]         rsp_kind,
   input wire logic                               rsp_slot,
   input wire logic signed [tfd_pkg::WORD_W-1:0]  rsp_value,
   input wire logic                               rsp_last
);
   import tfd_pkg::*;

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_value)
                                  && $stable(rsp_slot) && $stable(rsp_last))
      else $error("result payload changed while stalled");

   a_delta_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_X_NEG || rsp_kind == KIND_X_POS ||
                    rsp_kind == KIND_Y_NEG || rsp_kind == KIND_Y_POS)
      |-> rsp_value > 0)
      else $error("delta event without positive magnitude");

   a_abs_y_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ABS_Y) |-> rsp_value <= 0)
      else $error("absolute y event not negated");

endmodule

bind touchpad_finger_delta_tracker_unit tfd_checker u_tfd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.event_kind),
   .rsp_slot  (rsp_chan.finger_slot),
   .rsp_value (rsp_chan.event_value),
   .rsp_last  (rsp_chan.last)
);

`default_nettype wire

// ----- verif/tfd_event_checker.sv -----
`timescale 1ns / 1ps

module tfd_event_checker #(
   parameter int FINGERS = tfd_pkg::FINGERS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   tfd_req_if                              req,
   tfd_rsp_if                              rsp,
   input  logic                            csr_write,
   input  logic [tfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tfd_pkg::WORD_W-1:0]      csr_data,
   output int                              fail_count,
   output int                              outstanding,
   output int                              words_seen,
   output int                              events_seen
);
   import tfd_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic                     slot;
      logic signed [WORD_W-1:0] value;
      logic                     last;
   } touch_event_type;

   state_type         finger_state [FINGERS];
   logic [WORD_W-1:0] dead_zone;
   logic [WORD_W-1:0] scale_x;
   logic [WORD_W-1:0] scale_y;
   logic [WORD_W-1:0] inverse_width;
   logic [WORD_W-1:0] inverse_height;
   logic [AGE_W-1:0]  fling_window;
   touch_event_type   expected_events [$];
   int                reported;

   function automatic logic signed [WORD_W-1:0] clamp_word(input longint v);
      if (v > longint'(WORD_MAX)) return WORD_MAX;
      if (v < longint'(WORD_MIN)) return WORD_MIN;
      return v[WORD_W-1:0];
   endfunction

   // delta outside the dead zone becomes a negative or positive event
   function automatic bit axis_event(input logic signed [WORD_W-1:0] d,
                                     input logic [KIND_W-1:0] kneg,
                                     input logic [KIND_W-1:0] kpos,
                                     input logic f,
                                     output touch_event_type ev);
      longint zone;
      zone = longint'(dead_zone);
      ev.slot = f;
      ev.last = 1'b0;
      ev.kind = kneg;
      ev.value = '0;
      if (longint'(d) < -zone) begin
         ev.value = clamp_word(-longint'(d));
         return 1'b1;
      end
      if (longint'(d) > zone) begin
         ev.kind = kpos;
         ev.value = d;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [WORD_W-1:0] scaled_position(input logic [POS_W-1:0] p,
                                                         input logic [WORD_W-1:0] inv);
      logic [63:0] prod;
      prod = {52'd0, p} * {32'd0, inv} + 64'h8000;
      return prod[47:16];
   endfunction

   task automatic predict_touch_events(input logic f, input logic [WORD_W-1:0] w);
      state_type                s;
      touch_event_type          batch [$];
      touch_event_type          ev;
      logic                     down;
      logic [POS_W-1:0]         px;
      logic [POS_W-1:0]         py;
      logic                     changed;
      logic signed [WORD_W-1:0] dx;
      logic signed [WORD_W-1:0] dy;
      s = finger_state[f];
      down = ~w[7];
      px = w[19:8];
      py = w[31:20];
      changed = down != s.touching;
      dx = '0;
      dy = '0;
      if (changed) begin
         ev.kind = KIND_TOUCH;
         ev.slot = f;
         ev.value = down ? TOUCH_ONE : '0;
         ev.last = 1'b0;
         batch.push_back(ev);
         // release replays recent deltas
         if (!down) begin
            if (s.age_x < fling_window) dx = s.held_x;
            if (s.age_y < fling_window) dy = s.held_y;
         end
      end else begin
         dx = clamp_word((longint'(px) - longint'(s.last_x)) * longint'(scale_x));
         dy = clamp_word((longint'(py) - longint'(s.last_y)) * longint'(scale_y));
      end
      if (axis_event(dx, KIND_X_NEG, KIND_X_POS, f, ev)) begin
         batch.push_back(ev);
         s.held_x = dx;
         s.age_x = '0;
      end
      if (axis_event(dy, KIND_Y_NEG, KIND_Y_POS, f, ev)) begin
         batch.push_back(ev);
         s.held_y = dy;
         s.age_y = '0;
      end
      ev.slot = f;
      ev.last = 1'b0;
      if (s.age_x == '0 || changed) begin
         ev.kind = KIND_ABS_X;
         ev.value = scaled_position(px, inverse_width);
         batch.push_back(ev);
      end
      if (s.age_y == '0 || changed) begin
         ev.kind = KIND_ABS_Y;
         ev.value = -scaled_position(py, inverse_height);
         batch.push_back(ev);
      end
      s.touching = down;
      s.last_x = px;
      s.last_y = py;
      if (s.age_x != AGE_MAX) s.age_x = s.age_x + 1'b1;
      if (s.age_y != AGE_MAX) s.age_y = s.age_y + 1'b1;
      finger_state[f] = s;
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected_events.push_back(batch[i]);
   endtask

   always @(posedge clock) begin
      touch_event_type want;
      if (reset) begin
         dead_zone = DEAD_ZONE_RESET;
         scale_x = SCALE_X_RESET;
         scale_y = SCALE_Y_RESET;
         inverse_width = INVERSE_WIDTH_RESET;
         inverse_height = INVERSE_HEIGHT_RESET;
         fling_window = FLING_WINDOW_RESET;
         foreach (finger_state[i]) finger_state[i] = '0;
         expected_events.delete();
         fail_count = 0;
         reported = 0;
         words_seen = 0;
         events_seen = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DEAD_ZONE:      dead_zone = csr_data;
               CSR_SCALE_X:        scale_x = csr_data;
               CSR_SCALE_Y:        scale_y = csr_data;
               CSR_INVERSE_WIDTH:  inverse_width = csr_data;
               CSR_INVERSE_HEIGHT: inverse_height = csr_data;
               CSR_FLING_WINDOW:   fling_window = csr_data[AGE_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            events_seen++;
            if (expected_events.size() == 0) begin
               if (reported < 10)
                  $display("unexpected event: kind %0d slot %0d value %h last %0d",
                           rsp.event_kind, rsp.finger_slot, rsp.event_value, rsp.last);
               reported++;
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp.event_kind !== want.kind || rsp.finger_slot !== want.slot ||
                   rsp.event_value !== want.value || rsp.last !== want.last) begin
                  if (reported < 10)
                     $display("event mismatch: expected kind %0d slot %0d value %h last %0d, %s",
                              want.kind, want.slot, want.value, want.last,
                              $sformatf("got kind %0d slot %0d value %h last %0d",
                                        rsp.event_kind, rsp.finger_slot,
                                        rsp.event_value, rsp.last));
                  reported++;
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            words_seen++;
            predict_touch_events(req.finger, req.packed_touch);
         end
      end
      outstanding = expected_events.size();
   end

endmodule

// ----- verif/tb_touchpad_finger_delta_tracker_unit.sv -----
`timescale 1ns / 1ps

module tb_touchpad_finger_delta_tracker_unit;
   import tfd_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_data;
   int                     fail_count;
   int                     outstanding;
   int                     words_seen;
   int                     events_seen;
   int                     settings_used;
   bit                     no_gaps;
   logic                   pad_down [2];
   logic [POS_W-1:0]       pad_x [2];
   logic [POS_W-1:0]       pad_y [2];

   tfd_req_if req_chan ();
   tfd_rsp_if rsp_chan ();

   touchpad_finger_delta_tracker_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tfd_event_checker events_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .words_seen  (words_seen),
      .events_seen (events_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic program_regs(input logic [WORD_W-1:0] dz, input logic [WORD_W-1:0] sx,
                               input logic [WORD_W-1:0] sy, input logic [WORD_W-1:0] iw,
                               input logic [WORD_W-1:0] ih, input logic [WORD_W-1:0] fw);
      logic [CSR_INDEX_W-1:0] idx [6];
      logic [WORD_W-1:0]      val [6];
      idx = '{CSR_DEAD_ZONE, CSR_SCALE_X, CSR_SCALE_Y,
              CSR_INVERSE_WIDTH, CSR_INVERSE_HEIGHT, CSR_FLING_WINDOW};
      val = '{dz, sx, sy, iw, ih, fw};
      for (int i = 0; i < 6; i++) begin
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         @(negedge clock);
      end
      csr_write <= 1'b0;
      settings_used++;
   endtask

   task automatic send_word(input logic f, input logic [WORD_W-1:0] w);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.finger <= f;
      req_chan.packed_touch <= w;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pad_word(input logic down, input logic [POS_W-1:0] x,
                                                  input logic [POS_W-1:0] y);
      return {y, x, ~down, 7'($urandom())};
   endfunction

   // mostly coherent press / move / hold / release traffic, some raw noise
   task automatic send_random(input logic f);
      int               pick;
      int               span;
      logic [WORD_W-1:0] w;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         w = $urandom();
      end else begin
         if (pick < 25) begin
            pad_down[f] = ~pad_down[f];
         end else if (pick >= 40) begin
            span = (pick < 70) ? 3 : ((pick < 90) ? 64 : 4095);
            pad_x[f] = pad_x[f] + 12'($urandom_range(0, 2 * span) - span);
            pad_y[f] = pad_y[f] + 12'($urandom_range(0, 2 * span) - span);
         end
         w = pad_word(pad_down[f], pad_x[f], pad_y[f]);
      end
      pad_down[f] = ~w[7];
      pad_x[f] = w[19:8];
      pad_y[f] = w[31:20];
      send_word(f, w);
   endtask

   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [WORD_W-1:0] fw;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.finger = 1'b0;
      req_chan.packed_touch = '0;
      no_gaps = 1'b0;
      settings_used = 0;
      foreach (pad_down[i]) begin
         pad_down[i] = 1'b0;
         pad_x[i] = '0;
         pad_y[i] = '0;
      end
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      program_regs(DEAD_ZONE_RESET, SCALE_X_RESET, SCALE_Y_RESET, INVERSE_WIDTH_RESET,
                   INVERSE_HEIGHT_RESET, {24'd0, FLING_WINDOW_RESET});
      send_word(1'b0, pad_word(1'b1, 12'd0, 12'd0));
      send_word(1'b0, pad_word(1'b1, 12'd4095, 12'd4095));
      send_word(1'b0, pad_word(1'b1, 12'd0, 12'd0));
      send_word(1'b0, pad_word(1'b1, 12'd1, 12'd1));
      send_word(1'b0, pad_word(1'b1, 12'd1, 12'd1));
      send_word(1'b1, pad_word(1'b1, 12'd100, 12'd200));
      send_word(1'b0, pad_word(1'b0, 12'd2000, 12'd1000));
      send_word(1'b1, pad_word(1'b1, 12'd90, 12'd190));
      send_word(1'b1, 32'hFFFF_FFFF);
      send_word(1'b0, pad_word(1'b0, 12'd3000, 12'd3000));
      settle();

      // zero dead zone, full-scale gains: saturating deltas
      program_regs(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
      send_word(1'b0, 32'hFFFF_FF7F);
      send_word(1'b0, 32'h0000_0000);
      send_word(1'b0, 32'hFFFF_FF7F);
      send_word(1'b0, 32'hFFFF_FF00);
      send_word(1'b0, pad_word(1'b0, 12'd4095, 12'd4095));
      settle();

      // full dead zone, zero gains, no replay window
      program_regs(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_word(1'b1, pad_word(1'b1, 12'd4095, 12'd0));
      send_word(1'b1, pad_word(1'b1, 12'd0, 12'd4095));
      send_word(1'b1, pad_word(1'b0, 12'd0, 12'd4095));
      send_word(1'b0, 32'h0000_0000);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: program_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom());
            2: begin
               fw = {24'($urandom_range(0, 16777215)), 8'($urandom_range(200, 255))};
               program_regs($urandom_range(0, 200000), $urandom_range(0, 70000),
                            $urandom_range(0, 70000), $urandom(), $urandom(), fw);
            end
            default: program_regs($urandom_range(0, 200000), $urandom_range(0, 70000),
                                  $urandom_range(0, 70000), $urandom(), $urandom(),
                                  $urandom_range(0, 12));
         endcase
         for (int i = 0; i < 23; i++) begin
            if (i % 8 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            send_random(1'($urandom_range(0, 1)));
         end
         no_gaps = 1'b0;
         settle();
      end

      $display("checked %0d events produced by %0d touch words over both finger slots",
               events_seen, words_seen);
      $display("ran %0d register settings, zero and full-scale extremes included",
               settings_used);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
